// ===== rtl/core/markdown_heading_outline_scanner_macros.svh =====
// assertion macros for the markdown heading outline scanner
`ifndef MARKDOWN_HEADING_OUTLINE_SCANNER_MACROS_SVH
`define MARKDOWN_HEADING_OUTLINE_SCANNER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define MHOS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mhos same-cycle check failed");

// next-cycle implication, checked out of reset
`define MHOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mhos next-cycle check failed");

`else

`define MHOS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MHOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/mhos_pkg.sv =====
// shared types, constants and helpers of the markdown heading outline scanner
package mhos_pkg;

	localparam int LINE_BYTES    = 512;
	localparam int TITLE_BYTES   = 256;
	localparam int HEADING_LIMIT = 1024;
	localparam int COL_W         = $clog2(LINE_BYTES);
	localparam int OFS_W         = 9;
	localparam int CNT_W         = 20;
	localparam int LVL_W         = 3;
	localparam int STACK_DEPTH   = 6;
	localparam int SP_W          = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [LVL_W-1:0] DEEPEST_RESET = LVL_W'(6);

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;

	// input item
	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} byte_item_t;

	// result item
	typedef struct packed {
		logic [LVL_W-1:0] heading_level;
		logic [CNT_W-1:0] title_line;
		logic             from_previous_line;
		logic [OFS_W-1:0] title_start;
		logic [OFS_W-1:0] title_end;
		logic [CNT_W-1:0] heading_index;
		logic [CNT_W-1:0] parent_index;
		logic [LVL_W-1:0] tree_depth;
	} head_item_t;

	// line scan phase
	typedef enum logic [2:0] {
		PH_LEAD,
		PH_HASH,
		PH_GAP,
		PH_TITLE,
		PH_OTHER
	} phase_t;

	// outline unit sequencer
	typedef enum logic [0:0] {
		OL_IDLE,
		OL_SEARCH
	} ol_state_t;

	// heading found at a line end, before outline placement
	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [CNT_W-1:0] line;
		logic             prev;
		logic [OFS_W-1:0] start;
		logic [OFS_W-1:0] stop;
	} cand_t;

	// commands from the line scanner to the outline unit
	typedef struct packed {
		logic search;
		logic clear_doc;
	} ol_cmd_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ===== rtl/core/mhos_outline.sv =====
// outline unit: ancestor stack, heading numbering, parent search and result register
`include "markdown_heading_outline_scanner_macros.svh"

module mhos_outline
	import mhos_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ol_cmd_t    cmd,
	input  cand_t      cand,
	output logic       busy,
	output logic       head_valid,
	input  logic       head_stall,
	output head_item_t head_item
);

	ol_state_t state_q, state_d;

	logic [LVL_W-1:0] stk_level_q [STACK_DEPTH];
	logic [CNT_W-1:0] stk_index_q [STACK_DEPTH];
	logic [SP_W-1:0]  height_q;
	logic [CNT_W-1:0] kept_q;
	logic [SP_W-1:0]  h_q;
	cand_t            cand_q;
	logic             clear_after_q;
	logic             out_valid_q;
	head_item_t       out_item_q;

	logic [SP_W-1:0]  probe_idx;
	logic [LVL_W-1:0] probe_level;
	logic [CNT_W-1:0] probe_index;
	logic             found;
	logic             out_free;
	logic             finish;
	logic             step;
	logic [CNT_W-1:0] kept_next;
	logic             may_push;

	// one compare per cycle against the entry below the search pointer
	assign probe_idx   = h_q - SP_W'(1);
	assign probe_level = (h_q != '0) ? stk_level_q[probe_idx] : '0;
	assign probe_index = (h_q != '0) ? stk_index_q[probe_idx] : '0;
	assign found       = (h_q == '0) || (probe_level < cand_q.level);
	assign out_free    = !out_valid_q || !head_stall;
	assign kept_next   = (kept_q != CNT_MAX) ? kept_q + CNT_W'(1) : kept_q;
	assign may_push    = kept_q < CNT_W'(HEADING_LIMIT);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and step controls
	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		step    = 1'b0;
		unique case (state_q)
			OL_IDLE: begin
				if (cmd.search) begin
					state_d = OL_SEARCH;
				end
			end
			OL_SEARCH: begin
				if (!found) begin
					step = 1'b1;
				end else if (out_free) begin
					finish  = 1'b1;
					state_d = OL_IDLE;
				end
			end
			default: begin
				state_d = OL_IDLE;
			end
		endcase
	end

	assign busy = (state_q != OL_IDLE);

	// stack height, numbering and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q    <= '0;
			kept_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!head_stall) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				if (clear_after_q) begin
					height_q <= '0;
					kept_q   <= '0;
				end else begin
					kept_q <= kept_next;
					if (may_push && (h_q < SP_W'(STACK_DEPTH))) begin
						height_q <= h_q + SP_W'(1);
					end
				end
			end else if (cmd.clear_doc && !cmd.search) begin
				height_q <= '0;
				kept_q   <= '0;
			end
		end
	end

	// search pointer and captured heading
	always_ff @(posedge clk) begin
		if (state_q == OL_IDLE && cmd.search) begin
			cand_q        <= cand;
			h_q           <= height_q;
			clear_after_q <= cmd.clear_doc;
		end else if (step) begin
			h_q <= h_q - SP_W'(1);
		end
	end

	// stack entries, written on a push
	always_ff @(posedge clk) begin
		if (finish && may_push && (h_q < SP_W'(STACK_DEPTH))) begin
			stk_level_q[h_q] <= cand_q.level;
			stk_index_q[h_q] <= kept_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish) begin
			out_item_q.heading_level      <= cand_q.level;
			out_item_q.title_line         <= cand_q.line;
			out_item_q.from_previous_line <= cand_q.prev;
			out_item_q.title_start        <= cand_q.start;
			out_item_q.title_end          <= cand_q.stop;
			out_item_q.heading_index      <= kept_next;
			out_item_q.parent_index       <= probe_index;
			out_item_q.tree_depth         <= LVL_W'(h_q) + LVL_W'(1);
		end
	end

	assign head_valid = out_valid_q;
	assign head_item  = out_item_q;

	`MHOS_ASSERT_IMPLY(a_height_bound, clk, arst_n, 1'b1, height_q <= SP_W'(STACK_DEPTH))
	`MHOS_ASSERT_IMPLY(a_ptr_in_stack, clk, arst_n, state_q == OL_SEARCH, h_q <= height_q)
	`MHOS_ASSERT_IMPLY(a_no_overlap, clk, arst_n, cmd.search, state_q == OL_IDLE)
	`MHOS_ASSERT_NEXT(a_finish_shows, clk, arst_n, finish, out_valid_q && (state_q == OL_IDLE))

endmodule

// ===== rtl/core/markdown_heading_outline_scanner.sv =====
// Markdown heading scanner: takes one byte per cycle while the outline search does not stall input.
// A line end with a kept heading holds byte_stall while the outline unit walks the six-entry
// ancestor stack, one compare per cycle, and while head_stall still holds the result register.
// The result is registered once the search finds the parent and the result register is free.
// Reset clears line, document and stack state at once; deepest_level returns to 6.
module markdown_heading_outline_scanner
	import mhos_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_item,
	output logic       head_valid,
	input  logic       head_stall,
	output head_item_t head_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data
);

	logic [LVL_W-1:0] deepest_q;

	logic [COL_W-1:0] column_q;
	logic [CNT_W-1:0] line_count_q;
	phase_t           phase_q;
	logic [2:0]       hash_q;
	logic [COL_W-1:0] t_start_q, t_last_q, t_keep_q;
	logic             dead_q, has_text_q, first_hash_q, eq_ok_q, dash_ok_q, gap_ws_q;
	logic [COL_W-1:0] text_start_q, text_end_q;
	logic             prior_text_q, prior_hash_q;
	logic [COL_W-1:0] prior_start_q, prior_end_q;

	phase_t           phase_n;
	logic [2:0]       hash_n;
	logic [COL_W-1:0] t_start_n, t_last_n, t_keep_n;
	logic             dead_n, has_text_n, first_hash_n, eq_ok_n, dash_ok_n, gap_ws_n;
	logic [COL_W-1:0] text_start_n, text_end_n;
	logic [CNT_W-1:0] line_count_n;
	logic [COL_W-1:0] col_inc;
	logic             title_upd;

	logic [7:0]       c;
	logic             eoi;
	logic             accept;
	logic             line_end;
	logic             keep;
	cand_t            cand;
	logic [COL_W-1:0] c_start, c_end, c_span;
	ol_cmd_t          cmd;
	logic             busy;

	assign c      = byte_item.char_byte;
	assign eoi    = byte_item.end_of_input;
	assign accept = byte_valid && !byte_stall;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deepest_q <= DEEPEST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			deepest_q <= cfg_data;
		end
	end

	// per-byte line scan
	always_comb begin
		phase_n      = phase_q;
		hash_n       = hash_q;
		t_start_n    = t_start_q;
		t_last_n     = t_last_q;
		t_keep_n     = t_keep_q;
		dead_n       = dead_q;
		has_text_n   = has_text_q;
		first_hash_n = first_hash_q;
		eq_ok_n      = eq_ok_q;
		dash_ok_n    = dash_ok_q;
		gap_ws_n     = gap_ws_q;
		text_start_n = text_start_q;
		text_end_n   = text_end_q;
		title_upd    = 1'b0;
		col_inc      = column_q + COL_W'(1);
		line_count_n = line_count_q;
		if (column_q == '0 && line_count_q != CNT_MAX) begin
			line_count_n = line_count_q + CNT_W'(1);
		end
		if (!dead_q) begin
			if (c == CH_NUL) begin
				dead_n = 1'b1;
			end else if (is_ws(c)) begin
				if (has_text_q) begin
					gap_ws_n = 1'b1;
				end
				if (phase_q == PH_HASH) begin
					phase_n = (hash_q <= 3'd6) ? PH_GAP : PH_OTHER;
				end
			end else begin
				if (!has_text_q) begin
					has_text_n   = 1'b1;
					text_start_n = column_q;
					first_hash_n = (c == CH_HASH);
				end else if (gap_ws_q) begin
					eq_ok_n   = 1'b0;
					dash_ok_n = 1'b0;
				end
				gap_ws_n = 1'b0;
				if (c != CH_EQ) begin
					eq_ok_n = 1'b0;
				end
				if (c != CH_DASH) begin
					dash_ok_n = 1'b0;
				end
				text_end_n = col_inc;
				case (phase_q)
					PH_LEAD: begin
						if (c == CH_HASH) begin
							phase_n = PH_HASH;
							hash_n  = 3'd1;
						end else begin
							phase_n = PH_OTHER;
						end
					end
					PH_HASH: begin
						if (c == CH_HASH) begin
							if (hash_q < 3'd7) begin
								hash_n = hash_q + 3'd1;
							end
						end else begin
							phase_n = PH_OTHER;
						end
					end
					PH_GAP: begin
						phase_n   = PH_TITLE;
						t_start_n = column_q;
						t_last_n  = column_q;
						t_keep_n  = column_q;
						title_upd = 1'b1;
					end
					PH_TITLE: begin
						title_upd = 1'b1;
					end
					default: begin
					end
				endcase
				// trailing hash run tracking
				if (title_upd) begin
					if (c == CH_HASH) begin
						if (t_last_n != column_q) begin
							t_keep_n = t_last_n;
						end
						t_last_n = col_inc;
					end else begin
						t_keep_n = col_inc;
						t_last_n = col_inc;
					end
				end
			end
		end
	end

	assign line_end = (c == CH_NL) || (col_inc >= COL_W'(LINE_BYTES - 1)) || eoi;

	// heading candidate at line end, title clipped
	always_comb begin
		cand    = '0;
		c_start = '0;
		c_end   = '0;
		if (phase_n == PH_TITLE) begin
			cand.level = LVL_W'(hash_n);
			cand.line  = line_count_n;
			cand.prev  = 1'b0;
			c_start    = t_start_n;
			c_end      = t_keep_n;
		end else if (has_text_n && (eq_ok_n || dash_ok_n) && prior_text_q && !prior_hash_q) begin
			cand.level = eq_ok_n ? LVL_W'(1) : LVL_W'(2);
			cand.line  = line_count_n - CNT_W'(1);
			cand.prev  = 1'b1;
			c_start    = prior_start_q;
			c_end      = prior_end_q;
		end
		if (c_end < c_start) begin
			c_end = c_start;
		end
		c_span = c_end - c_start;
		if (c_span > COL_W'(TITLE_BYTES - 1)) begin
			c_end = c_start + COL_W'(TITLE_BYTES - 1);
		end
		cand.start = OFS_W'(c_start);
		cand.stop  = OFS_W'(c_end);
	end

	assign keep = (cand.level != '0) && (cand.level <= deepest_q);

	assign cmd.search    = accept && line_end && keep;
	assign cmd.clear_doc = accept && line_end && eoi;

	assign byte_stall = busy;

	// line and document state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= '0;
			line_count_q  <= '0;
			phase_q       <= PH_LEAD;
			hash_q        <= '0;
			t_start_q     <= '0;
			t_last_q      <= '0;
			t_keep_q      <= '0;
			dead_q        <= 1'b0;
			has_text_q    <= 1'b0;
			first_hash_q  <= 1'b0;
			eq_ok_q       <= 1'b1;
			dash_ok_q     <= 1'b1;
			gap_ws_q      <= 1'b0;
			text_start_q  <= '0;
			text_end_q    <= '0;
			prior_text_q  <= 1'b0;
			prior_hash_q  <= 1'b0;
			prior_start_q <= '0;
			prior_end_q   <= '0;
		end else if (accept) begin
			if (line_end) begin
				column_q     <= '0;
				phase_q      <= PH_LEAD;
				hash_q       <= '0;
				t_start_q    <= '0;
				t_last_q     <= '0;
				t_keep_q     <= '0;
				dead_q       <= 1'b0;
				has_text_q   <= 1'b0;
				first_hash_q <= 1'b0;
				eq_ok_q      <= 1'b1;
				dash_ok_q    <= 1'b1;
				gap_ws_q     <= 1'b0;
				text_start_q <= '0;
				text_end_q   <= '0;
				if (eoi) begin
					line_count_q  <= '0;
					prior_text_q  <= 1'b0;
					prior_hash_q  <= 1'b0;
					prior_start_q <= '0;
					prior_end_q   <= '0;
				end else begin
					line_count_q  <= line_count_n;
					prior_text_q  <= has_text_n;
					prior_hash_q  <= first_hash_n;
					prior_start_q <= text_start_n;
					prior_end_q   <= text_end_n;
				end
			end else begin
				column_q     <= col_inc;
				line_count_q <= line_count_n;
				phase_q      <= phase_n;
				hash_q       <= hash_n;
				t_start_q    <= t_start_n;
				t_last_q     <= t_last_n;
				t_keep_q     <= t_keep_n;
				dead_q       <= dead_n;
				has_text_q   <= has_text_n;
				first_hash_q <= first_hash_n;
				eq_ok_q      <= eq_ok_n;
				dash_ok_q    <= dash_ok_n;
				gap_ws_q     <= gap_ws_n;
				text_start_q <= text_start_n;
				text_end_q   <= text_end_n;
			end
		end
	end

	// outline placement and result register
	mhos_outline u_outline (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cand       (cand),
		.busy       (busy),
		.head_valid (head_valid),
		.head_stall (head_stall),
		.head_item  (head_item)
	);

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the markdown heading outline scanner
`timescale 1ns / 100ps

module testbench;
	import mhos_pkg::*;

	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_BYTES   = 220;
	// deepest_level per random phase, first entry in the low bits
	localparam logic [20:0] LEVEL_PLAN = {3'd6, 3'd4, 3'd5, 3'd2, 3'd6, 3'd3, 3'd1};

	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_TOP   = 8'hff;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	byte_item_t byte_item = '0;
	logic       head_valid;
	logic       head_stall = 1'b0;
	head_item_t head_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_data = '0;

	markdown_heading_outline_scanner dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.head_valid (head_valid),
		.head_stall (head_stall),
		.head_item  (head_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// stimulus and expectation stores
	byte_item_t  pending_bytes[$];
	head_item_t  expected_heads[$];
	logic [7:0]  text_buf[$];
	int unsigned queued_count = 0;
	int unsigned bytes_taken = 0;
	int unsigned mismatches = 0;
	int unsigned hold_tokens = 0;

	// scanner state mirror
	logic [2:0]  deepest_q;
	int unsigned col_q, line_q, hash_q;
	phase_t      phase_q;
	int unsigned tstart_q, tlast_q, tkeep_q;
	bit          dead_q, text_q, first_hash_q, eq_q, dash_q, gap_q;
	int unsigned txt_start_q, txt_end_q;
	bit          prev_text_q, prev_hash_q;
	int unsigned prev_start_q, prev_end_q;
	int unsigned kept_q, height_q;
	int unsigned anc_level[6];
	int unsigned anc_index[6];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void restart_line();
		col_q = 0;
		phase_q = PH_LEAD;
		hash_q = 0;
		tstart_q = 0;
		tlast_q = 0;
		tkeep_q = 0;
		dead_q = 1'b0;
		text_q = 1'b0;
		first_hash_q = 1'b0;
		eq_q = 1'b1;
		dash_q = 1'b1;
		gap_q = 1'b0;
		txt_start_q = 0;
		txt_end_q = 0;
	endfunction

	function automatic void restart_document();
		restart_line();
		line_q = 0;
		prev_text_q = 1'b0;
		prev_hash_q = 1'b0;
		prev_start_q = 0;
		prev_end_q = 0;
		kept_q = 0;
		height_q = 0;
		for (int i = 0; i < 6; i++) begin
			anc_level[i] = 0;
			anc_index[i] = 0;
		end
	endfunction

	// advance the scanner by one byte, queue the heading it completes
	function automatic void predict_heading(input byte_item_t it);
		logic [7:0]  c;
		bit          blank, in_title, push_ok, prv;
		int unsigned pos, lvl, st, en, ln, h, par;
		head_item_t  r;
		c = it.char_byte;
		in_title = 1'b0;
		if (col_q == 0 && line_q < CNT_MAX)
			line_q++;
		pos = col_q;
		col_q++;
		blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		// line content, ignored after a zero byte
		if (!dead_q) begin
			if (c == CH_NUL) begin
				dead_q = 1'b1;
			end else if (blank) begin
				if (text_q)
					gap_q = 1'b1;
				if (phase_q == PH_HASH)
					phase_q = (hash_q <= 6) ? PH_GAP : PH_OTHER;
			end else begin
				if (!text_q) begin
					text_q = 1'b1;
					txt_start_q = pos;
					first_hash_q = (c == CH_HASH);
				end else if (gap_q) begin
					eq_q = 1'b0;
					dash_q = 1'b0;
				end
				gap_q = 1'b0;
				if (c != CH_EQ)
					eq_q = 1'b0;
				if (c != CH_DASH)
					dash_q = 1'b0;
				txt_end_q = pos + 1;
				case (phase_q)
					PH_LEAD: begin
						if (c == CH_HASH) begin
							phase_q = PH_HASH;
							hash_q = 1;
						end else begin
							phase_q = PH_OTHER;
						end
					end
					PH_HASH: begin
						if (c != CH_HASH)
							phase_q = PH_OTHER;
						else if (hash_q < 7)
							hash_q++;
					end
					PH_GAP: begin
						phase_q = PH_TITLE;
						tstart_q = pos;
						tlast_q = pos;
						tkeep_q = pos;
						in_title = 1'b1;
					end
					PH_TITLE: in_title = 1'b1;
					default: ;
				endcase
				// trailing hash run is held back until a later title byte
				if (in_title) begin
					if (c == CH_HASH) begin
						if (tlast_q != pos)
							tkeep_q = tlast_q;
						tlast_q = pos + 1;
					end else begin
						tkeep_q = pos + 1;
						tlast_q = pos + 1;
					end
				end
			end
		end
		// line end: classify and place in the outline
		if (c == CH_NL || col_q >= LINE_BYTES - 1 || it.end_of_input) begin
			lvl = 0;
			st = 0;
			en = 0;
			ln = 0;
			prv = 1'b0;
			if (phase_q == PH_TITLE) begin
				lvl = hash_q;
				st = tstart_q;
				en = tkeep_q;
				ln = line_q;
			end else if (text_q && (eq_q || dash_q) && prev_text_q && !prev_hash_q) begin
				lvl = eq_q ? 1 : 2;
				st = prev_start_q;
				en = prev_end_q;
				ln = line_q - 1;
				prv = 1'b1;
			end
			if (en < st)
				en = st;
			if (en - st > TITLE_BYTES - 1)
				en = st + TITLE_BYTES - 1;
			if (lvl != 0 && lvl <= deepest_q) begin
				push_ok = kept_q < HEADING_LIMIT;
				if (kept_q < CNT_MAX)
					kept_q++;
				h = (height_q > 6) ? 6 : height_q;
				while (h > 0 && anc_level[h-1] >= lvl)
					h--;
				par = (h > 0) ? anc_index[h-1] : 0;
				if (push_ok && h < 6) begin
					anc_level[h] = lvl;
					anc_index[h] = kept_q;
					height_q = h + 1;
				end
				r.heading_level = LVL_W'(lvl);
				r.title_line = CNT_W'(ln);
				r.from_previous_line = prv;
				r.title_start = OFS_W'(st);
				r.title_end = OFS_W'(en);
				r.heading_index = CNT_W'(kept_q);
				r.parent_index = CNT_W'(par);
				r.tree_depth = LVL_W'(h + 1);
				expected_heads.push_back(r);
			end
			prev_text_q = text_q;
			prev_hash_q = first_hash_q;
			prev_start_q = txt_start_q;
			prev_end_q = txt_end_q;
			if (it.end_of_input)
				restart_document();
			else
				restart_line();
		end
	endfunction

	function automatic string show_head(input head_item_t h);
		return $sformatf("lvl %0d line %0d prev %0d start %0d end %0d idx %0d parent %0d depth %0d",
			h.heading_level, h.title_line, h.from_previous_line, h.title_start,
			h.title_end, h.heading_index, h.parent_index, h.tree_depth);
	endfunction

	// byte sender: bursts of random length with random gaps
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		bit         take, fire;
		byte_item_t nxt;
		take = arst_n && byte_valid && !byte_stall;
		nxt = byte_item;
		fire = 1'b0;
		if (take) begin
			predict_heading(byte_item);
			bytes_taken++;
		end
		if (arst_n && (!byte_valid || take)) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_bytes.size() > 0) begin
				nxt = pending_bytes.pop_front();
				fire = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else if ($urandom_range(0, 9) < 3) begin
					burst_left = $urandom_range(50, 200);
					gap_left = 0;
				end else begin
					burst_left = $urandom_range(1, 30);
					gap_left = $urandom_range(1, 10);
				end
			end
			byte_valid <= fire;
			byte_item <= nxt;
		end
	end

	// heading receiver stall pattern, with an occasional long hold-off
	int unsigned holds_done = 0;
	int unsigned hold_left = 0;
	int unsigned seg_left = 0;
	int unsigned seg_mode = 0;
	int unsigned tick = 0;

	always @(posedge clk) begin
		bit s;
		tick++;
		if (hold_tokens != holds_done) begin
			holds_done++;
			hold_left = LONG_HOLD;
		end
		if (seg_left == 0) begin
			seg_mode = $urandom_range(0, 3);
			seg_left = $urandom_range(20, 200);
		end else begin
			seg_left--;
		end
		case (seg_mode)
			0: s = 1'b0;
			1: s = ($urandom_range(0, 3) == 0);
			2: s = ($urandom_range(0, 9) < 7);
			default: s = (tick % 5) < 2;
		endcase
		if (hold_left > 0) begin
			hold_left--;
			s = 1'b1;
		end
		head_stall <= s;
	end

	// heading checker
	always @(posedge clk) begin
		head_item_t want;
		if (arst_n && head_valid && !head_stall) begin
			if (expected_heads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected heading: %s", show_head(head_item));
			end else begin
				want = expected_heads.pop_front();
				if (head_item.heading_level !== want.heading_level ||
					head_item.title_line !== want.title_line ||
					head_item.from_previous_line !== want.from_previous_line ||
					head_item.title_start !== want.title_start ||
					head_item.title_end !== want.title_end ||
					head_item.heading_index !== want.heading_index ||
					head_item.parent_index !== want.parent_index ||
					head_item.tree_depth !== want.tree_depth) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("heading mismatch at %0t", $realtime);
						$display("  expected %s", show_head(want));
						$display("  actual   %s", show_head(head_item));
					end
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (head_valid && !head_stall) ||
				(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// move the composed bytes to the send queue
	task automatic flush(input bit eoi_last);
		logic [7:0] c;
		while (text_buf.size() > 0) begin
			c = text_buf.pop_front();
			pending_bytes.push_back(byte_item_t'{c, eoi_last && text_buf.size() == 0});
			queued_count++;
		end
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 19))
			0: return CH_HASH;
			1: return CH_SPACE;
			2: return CH_EQ;
			3: return CH_DASH;
			default: return CH_LOW_A + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 5))
			0: return CH_TAB;
			1: return CH_CR;
			2: return CH_VT;
			3: return CH_FF;
			default: return CH_SPACE;
		endcase
	endfunction

	// run of '=' or '-', sometimes broken by a space or the other mark
	task automatic compose_underline();
		logic [7:0] u;
		u = $urandom_range(0, 1) ? CH_EQ : CH_DASH;
		if ($urandom_range(0, 4) == 0)
			text_buf.push_back(blank_char());
		repeat ($urandom_range(1, 6))
			text_buf.push_back(u);
		case ($urandom_range(0, 9))
			0: begin
				text_buf.push_back(CH_SPACE);
				text_buf.push_back(u);
			end
			1: text_buf.push_back((u == CH_EQ) ? CH_DASH : CH_EQ);
			default: ;
		endcase
		if ($urandom_range(0, 4) == 0)
			text_buf.push_back(blank_char());
	endtask

	// one random line, mostly heading shapes with random content
	task automatic compose_line();
		int unsigned kind, r;
		kind = $urandom_range(0, 199);
		if (kind < 60) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) text_buf.push_back(blank_char());
			repeat (($urandom_range(0, 9) == 0) ? 7 : $urandom_range(1, 6))
				text_buf.push_back(CH_HASH);
			if ($urandom_range(0, 9) != 0)
				repeat ($urandom_range(1, 2)) text_buf.push_back(blank_char());
			repeat ($urandom_range(0, 12))
				text_buf.push_back(word_char());
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(0, 2)) text_buf.push_back(blank_char());
				repeat ($urandom_range(1, 3)) text_buf.push_back(CH_HASH);
				repeat ($urandom_range(0, 2)) text_buf.push_back(blank_char());
			end
		end else if (kind < 100) begin
			if ($urandom_range(0, 4) == 0)
				text_buf.push_back(CH_HASH);
			repeat ($urandom_range(1, 10))
				text_buf.push_back(word_char());
			text_buf.push_back(CH_NL);
			compose_underline();
		end else if (kind < 130) begin
			compose_underline();
		end else if (kind < 145) begin
			repeat ($urandom_range(0, 3)) text_buf.push_back(blank_char());
		end else if (kind < 175) begin
			repeat ($urandom_range(1, 20)) text_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 197) begin
			repeat ($urandom_range(1, 30)) text_buf.push_back(word_char());
		end else begin
			// long line: split at the line limit, title clipped
			if ($urandom_range(0, 1)) begin
				text_buf.push_back(CH_HASH);
				text_buf.push_back(CH_SPACE);
			end
			repeat ($urandom_range(250, 540)) text_buf.push_back(word_char());
		end
		// usually newline, sometimes end of input with or without one
		r = $urandom_range(0, 99);
		if (r < 3 && text_buf.size() > 0) begin
			flush(1'b1);
		end else begin
			text_buf.push_back(CH_NL);
			flush(r < 6);
		end
	endtask

	// wait until every byte is in and every heading is out
	task automatic settle();
		while (bytes_taken != queued_count || expected_heads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_deepest(input logic [2:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		deepest_q = v;
	endtask

	// test sequence
	initial begin
		int unsigned goal;
		restart_document();
		deepest_q = DEEPEST_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_deepest(DEEPEST_RESET);

		// directed: atx with closing hashes, setext, zero byte, top byte, end of input
		queue_text("# a #\n");
		queue_text("b\n-\n");
		queue_text("## ");
		text_buf.push_back(CH_NUL);
		queue_text("c\n");
		text_buf.push_back(CH_TOP);
		text_buf.push_back(CH_NL);
		queue_text("d\n=");
		flush(1'b1);
		settle();

		// random phases over several level limits
		for (int p = 0; p < 7; p++) begin
			write_deepest(LEVEL_PLAN[3*p +: 3]);
			goal = queued_count + PHASE_BYTES;
			if (p == 1)
				hold_tokens++;
			if (p == 3) begin
				while (queued_count < goal - PHASE_BYTES / 2)
					compose_line();
				settle();
			end
			while (queued_count < goal)
				compose_line();
			settle();
		end

		if (mismatches == 0 && expected_heads.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
